### src/mm6_pkg.sv
package mm6_pkg;

   localparam int OP_W  = 2;
   localparam int IDX_W = 6;
   localparam int VAL_W = 32;
   localparam int POS_W = 3;

   localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DRAIN
   } seq_state_type;

   // Travels with each read pair through the multiply-accumulate pipeline.
   typedef struct packed {
      logic             first_k;
      logic             last_k;
      logic             last;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } mac_tag_type;

endpackage

### src/mm6_store.sv
module mm6_store #(
   parameter int CELLS   = 36,
   parameter int CELL_AW = 6
) (
   input  logic                          clock,
   input  logic                          wr_en_left,
   input  logic                          wr_en_right,
   input  logic [CELL_AW-1:0]            wr_addr,
   input  logic [mm6_pkg::VAL_W-1:0]     wr_data,
   input  logic                          rd_en,
   input  logic [CELL_AW-1:0]            rd_addr_left,
   input  logic [CELL_AW-1:0]            rd_addr_right,
   output logic [mm6_pkg::VAL_W-1:0]     rd_data_left,
   output logic [mm6_pkg::VAL_W-1:0]     rd_data_right
);

   logic [mm6_pkg::VAL_W-1:0] left_mem  [CELLS];
   logic [mm6_pkg::VAL_W-1:0] right_mem [CELLS];

   always_ff @(posedge clock) begin
      if (wr_en_left) begin
         left_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_left <= left_mem[rd_addr_left];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_right) begin
         right_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_right <= right_mem[rd_addr_right];
      end
   end

endmodule

### src/mm6_seq.sv
module mm6_seq #(
   parameter int DIM     = 6,
   parameter int CELL_AW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_compute,
   input  logic                 drain_done,
   output logic                 busy,
   output logic                 rd_en,
   output logic [CELL_AW-1:0]   rd_addr_left,
   output logic [CELL_AW-1:0]   rd_addr_right,
   output mm6_pkg::mac_tag_type issue_tag
);

   localparam int CNT_W = $clog2(DIM);

   mm6_pkg::seq_state_type state_ff, state_in;

   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   c_ff, c_in;
   logic [CNT_W-1:0]   r_ff, r_in;
   logic [CELL_AW-1:0] addr_left_ff, addr_left_in;
   logic [CELL_AW-1:0] addr_right_ff, addr_right_in;

   logic k_last, c_last, r_last, final_issue;

   assign k_last      = (k_ff == CNT_W'(DIM - 1));
   assign c_last      = (c_ff == CNT_W'(DIM - 1));
   assign r_last      = (r_ff == CNT_W'(DIM - 1));
   assign final_issue = k_last && c_last && r_last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm6_pkg::SEQ_IDLE: begin
            if (start_compute) begin
               state_in = mm6_pkg::SEQ_RUN;
            end
         end
         mm6_pkg::SEQ_RUN: begin
            if (final_issue) begin
               state_in = mm6_pkg::SEQ_DRAIN;
            end
         end
         mm6_pkg::SEQ_DRAIN: begin
            if (drain_done) begin
               state_in = mm6_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = mm6_pkg::SEQ_IDLE;
         end
      endcase
   end

   // The left address walks along a row and the right address down a column;
   // both step back after each dot product, but after a row the left moves on.
   always_comb begin
      k_in          = k_ff;
      c_in          = c_ff;
      r_in          = r_ff;
      addr_left_in  = addr_left_ff;
      addr_right_in = addr_right_ff;
      case (state_ff)
         mm6_pkg::SEQ_IDLE: begin
            k_in          = '0;
            c_in          = '0;
            r_in          = '0;
            addr_left_in  = '0;
            addr_right_in = '0;
         end
         mm6_pkg::SEQ_RUN: begin
            if (k_last) begin
               k_in = '0;
               if (c_last) begin
                  c_in          = '0;
                  r_in          = r_ff + CNT_W'(1);
                  addr_left_in  = addr_left_ff + CELL_AW'(1);
                  addr_right_in = '0;
               end else begin
                  c_in          = c_ff + CNT_W'(1);
                  addr_left_in  = addr_left_ff - CELL_AW'(DIM - 1);
                  addr_right_in = addr_right_ff - CELL_AW'(DIM * DIM - DIM - 1);
               end
            end else begin
               k_in          = k_ff + CNT_W'(1);
               addr_left_in  = addr_left_ff + CELL_AW'(1);
               addr_right_in = addr_right_ff + CELL_AW'(DIM);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      busy              = (state_ff != mm6_pkg::SEQ_IDLE);
      rd_en             = (state_ff == mm6_pkg::SEQ_RUN);
      rd_addr_left      = addr_left_ff;
      rd_addr_right     = addr_right_ff;
      issue_tag.first_k = (k_ff == '0);
      issue_tag.last_k  = k_last;
      issue_tag.last    = final_issue;
      issue_tag.row     = mm6_pkg::POS_W'(r_ff);
      issue_tag.col     = mm6_pkg::POS_W'(c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm6_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff          <= '0;
         c_ff          <= '0;
         r_ff          <= '0;
         addr_left_ff  <= '0;
         addr_right_ff <= '0;
      end else begin
         k_ff          <= k_in;
         c_ff          <= c_in;
         r_ff          <= r_in;
         addr_left_ff  <= addr_left_in;
         addr_right_ff <= addr_right_in;
      end
   end

endmodule

### src/mm6_mac.sv
module mm6_mac #(
   parameter int DIM       = 6,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               issue_valid,
   input  mm6_pkg::mac_tag_type               issue_tag,
   input  logic [mm6_pkg::VAL_W-1:0]          left_data,
   input  logic [mm6_pkg::VAL_W-1:0]          right_data,
   output logic                               rsp_valid,
   output logic [mm6_pkg::POS_W-1:0]          rsp_row,
   output logic [mm6_pkg::POS_W-1:0]          rsp_col,
   output logic signed [mm6_pkg::VAL_W-1:0]   rsp_value,
   output logic                               rsp_last
);

   localparam int PROD_W = 2 * mm6_pkg::VAL_W;
   localparam int ACC_W  = PROD_W + $clog2(DIM);
   localparam logic signed [mm6_pkg::VAL_W-1:0] SAT_MAX = {1'b0, {(mm6_pkg::VAL_W-1){1'b1}}};
   localparam logic signed [mm6_pkg::VAL_W-1:0] SAT_MIN = {1'b1, {(mm6_pkg::VAL_W-1){1'b0}}};

   logic                 valid_s1_ff, valid_s1_in;
   logic                 valid_s2_ff, valid_s2_in;
   logic                 valid_s3_ff, valid_s3_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mm6_pkg::mac_tag_type tag_s1_ff, tag_s2_ff, tag_s3_ff;
   mm6_pkg::mac_tag_type tag_s2_in, tag_s3_in;

   logic signed [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic signed [ACC_W-1:0]           prod_ext;
   logic signed [ACC_W-1:0]           shifted;
   logic [ACC_W-mm6_pkg::VAL_W:0]     upper;
   logic signed [mm6_pkg::VAL_W-1:0]  sat_value;
   logic signed [mm6_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [mm6_pkg::POS_W-1:0]         row_ff, col_ff;
   logic                              last_ff;

   // Stage one: read data arrives from the stores. Stage two: product.
   // Stage three: accumulate. Then shift, saturate and present the result.
   assign valid_s1_in = issue_valid;
   assign valid_s2_in = valid_s1_ff;
   assign tag_s2_in   = tag_s1_ff;
   assign prod_in     = $signed(left_data) * $signed(right_data);

   assign prod_ext    = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign valid_s3_in = valid_s2_ff && tag_s2_ff.last_k;
   assign tag_s3_in   = tag_s2_ff;

   always_comb begin
      acc_in = acc_ff;
      if (valid_s2_ff) begin
         if (tag_s2_ff.first_k) begin
            acc_in = prod_ext;
         end else begin
            acc_in = acc_ff + prod_ext;
         end
      end
   end

   // The value fits when every bit above the result's sign bit repeats it.
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[ACC_W-1:mm6_pkg::VAL_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat_value = shifted[mm6_pkg::VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_value = SAT_MIN;
      end else begin
         sat_value = SAT_MAX;
      end
   end

   assign rsp_valid_in = valid_s3_ff;
   assign value_in     = sat_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff  <= 1'b0;
         valid_s2_ff  <= 1'b0;
         valid_s3_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_s1_ff  <= valid_s1_in;
         valid_s2_ff  <= valid_s2_in;
         valid_s3_ff  <= valid_s3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_s1_ff <= issue_tag;
      tag_s2_ff <= tag_s2_in;
      tag_s3_ff <= tag_s3_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      value_ff  <= value_in;
      row_ff    <= tag_s3_ff.row;
      col_ff    <= tag_s3_ff.col;
      last_ff   <= tag_s3_ff.last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = row_ff;
   assign rsp_col   = col_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule

### src/matrix_multiply_6x6.sv
// Channel   Ports                                               Handshake
// request   req_operation, req_element_index, req_element_value start high, busy low
// response  rsp_out_row, rsp_out_col, rsp_product_value, rsp_last rsp_valid, one cycle
//
// A load transaction writes one element of the left or right store if the index is in range.
// A compute transaction keeps busy high through one multiply-accumulate per cycle,
// fed by one read port of each store, then a four-stage drain.
// Results leave row-major, each valid for a single cycle.
// Reset clears control only; the stores hold garbage until loaded.
// The receiver cannot stall; rsp_valid is a strobe.
module matrix_multiply_6x6 #(
   parameter int DIM       = 6,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mm6_pkg::OP_W-1:0]            req_operation,
   input  logic [mm6_pkg::IDX_W-1:0]           req_element_index,
   input  logic signed [mm6_pkg::VAL_W-1:0]    req_element_value,
   output logic                                rsp_valid,
   output logic [mm6_pkg::POS_W-1:0]           rsp_out_row,
   output logic [mm6_pkg::POS_W-1:0]           rsp_out_col,
   output logic signed [mm6_pkg::VAL_W-1:0]    rsp_product_value,
   output logic                                rsp_last
);

   localparam int CELLS   = DIM * DIM;
   localparam int CELL_AW = $clog2(CELLS);

   logic                      accept;
   logic                      in_range;
   logic                      wr_en_left;
   logic                      wr_en_right;
   logic                      start_compute;
   logic                      drain_done;
   logic                      rd_en;
   logic [CELL_AW-1:0]        wr_addr;
   logic [CELL_AW-1:0]        rd_addr_left;
   logic [CELL_AW-1:0]        rd_addr_right;
   logic [mm6_pkg::VAL_W-1:0] rd_data_left;
   logic [mm6_pkg::VAL_W-1:0] rd_data_right;
   mm6_pkg::mac_tag_type      issue_tag;

   assign accept   = start && !busy;
   assign in_range = (32'(req_element_index) < CELLS);
   assign wr_addr  = CELL_AW'(req_element_index);

   // Loads land only while idle, so a compute never reads an entry in flight.
   always_comb begin
      wr_en_left    = 1'b0;
      wr_en_right   = 1'b0;
      start_compute = 1'b0;
      case (req_operation)
         mm6_pkg::OP_LOAD_LEFT: begin
            wr_en_left = accept && in_range;
         end
         mm6_pkg::OP_LOAD_RIGHT: begin
            wr_en_right = accept && in_range;
         end
         mm6_pkg::OP_COMPUTE: begin
            start_compute = accept;
         end
         default: begin
         end
      endcase
   end

   assign drain_done = rsp_valid && rsp_last;

   mm6_store #(
      .CELLS   (CELLS),
      .CELL_AW (CELL_AW)
   ) u_store (
      .clock         (clock),
      .wr_en_left    (wr_en_left),
      .wr_en_right   (wr_en_right),
      .wr_addr       (wr_addr),
      .wr_data       (req_element_value),
      .rd_en         (rd_en),
      .rd_addr_left  (rd_addr_left),
      .rd_addr_right (rd_addr_right),
      .rd_data_left  (rd_data_left),
      .rd_data_right (rd_data_right)
   );

   mm6_seq #(
      .DIM     (DIM),
      .CELL_AW (CELL_AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start_compute (start_compute),
      .drain_done    (drain_done),
      .busy          (busy),
      .rd_en         (rd_en),
      .rd_addr_left  (rd_addr_left),
      .rd_addr_right (rd_addr_right),
      .issue_tag     (issue_tag)
   );

   mm6_mac #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (rd_en),
      .issue_tag   (issue_tag),
      .left_data   (rd_data_left),
      .right_data  (rd_data_right),
      .rsp_valid   (rsp_valid),
      .rsp_row     (rsp_out_row),
      .rsp_col     (rsp_out_col),
      .rsp_value   (rsp_product_value),
      .rsp_last    (rsp_last)
   );

endmodule
